@@ rtl/rgbhsv_pkg.sv @@
`default_nettype none

package rgbhsv_pkg;

    localparam int CH_W   = 8;
    localparam int HUE_W  = 15;
    localparam int QUO_W  = 12;            // hue offset is at most 3840
    localparam int NUM_W  = CH_W + QUO_W;  // dividend width

    localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_CIRCLE = 15'd23040;

    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } t_sector;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [HUE_W-1:0] hue_out;
        logic [CH_W-1:0]  saturation_out;
        logic [CH_W-1:0]  value_out;
    } t_hsv_out;

    // per-pixel info that rides alongside the dividers
    typedef struct packed {
        logic [CH_W-1:0] value;
        logic [CH_W-1:0] delta;
        logic            neg;
        t_sector         sector;
        logic            black;
        logic            grey;
    } t_side;

endpackage

`default_nettype wire

@@ rtl/rgbhsv_divider.sv @@
`default_nettype none

// Restoring divider, one quotient bit per stage.
// Caller guarantees quotient < 2**QUO_W, i.e. the top CH_W dividend bits are
// below the divisor.
module rgbhsv_divider (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [rgbhsv_pkg::NUM_W-1:0]    i_dividend,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]     i_divisor,
    output logic      [rgbhsv_pkg::QUO_W-1:0]    o_quotient
);

    localparam int CW = rgbhsv_pkg::CH_W;
    localparam int QW = rgbhsv_pkg::QUO_W;

    logic [CW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [QW-1:0] r_quo [QW];
    logic [CW-1:0] r_dv  [QW];

    logic [CW-1:0] n_rem [QW];
    logic [QW-1:0] n_lo  [QW];
    logic [QW-1:0] n_quo [QW];
    logic [CW-1:0] n_dv  [QW];

    always_comb begin
        logic [CW-1:0] s_rem;
        logic [QW-1:0] s_lo;
        logic [QW-1:0] s_quo;
        logic [CW-1:0] s_dv;
        logic [CW:0]   trial;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                s_rem = i_dividend[rgbhsv_pkg::NUM_W-1:QW];
                s_lo  = i_dividend[QW-1:0];
                s_quo = '0;
                s_dv  = i_divisor;
            end else begin
                s_rem = r_rem[k-1];
                s_lo  = r_lo[k-1];
                s_quo = r_quo[k-1];
                s_dv  = r_dv[k-1];
            end
            trial = {s_rem, s_lo[QW-1]};
            if (trial >= {1'b0, s_dv}) begin
                n_rem[k] = CW'(trial - {1'b0, s_dv});
                n_quo[k] = {s_quo[QW-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[CW-1:0];
                n_quo[k] = {s_quo[QW-2:0], 1'b0};
            end
            n_lo[k] = {s_lo[QW-2:0], 1'b0};
            n_dv[k] = s_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_lo[k]  <= n_lo[k];
                r_quo[k] <= n_quo[k];
                r_dv[k]  <= n_dv[k];
            end
        end
    end

    assign o_quotient = r_quo[QW-1];

endmodule

`default_nettype wire

@@ rtl/rgb_to_hsv_converter.sv @@
`default_nettype none

// RGB to HSV converter. Takes one 8-bit RGB pixel per clock and returns hue
// (1/64 degree, 0..23039), saturation (255 = 1.0, truncated) and value (max
// channel). Fully pipelined: one pixel per clock sustained while the output
// is not stalled. The pipeline is a min/max stage, a dividend stage, the two
// 12-stage restoring dividers (one quotient bit per stage) for saturation and
// hue offset, and an output register.
// When the output is held by i_stall the whole pipeline freezes and o_stall
// is raised.
module rgb_to_hsv_converter (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire rgbhsv_pkg::t_pix_in   i_pix,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output rgbhsv_pkg::t_hsv_out       o_hsv
);

    localparam int CW = rgbhsv_pkg::CH_W;
    localparam int QW = rgbhsv_pkg::QUO_W;
    localparam int NW = rgbhsv_pkg::NUM_W;
    localparam int HW = rgbhsv_pkg::HUE_W;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // ---- stage 1: max, min, sector, signed difference
    logic [CW-1:0]       r, g, b, mx, mn;
    logic [CW:0]         diff;
    rgbhsv_pkg::t_sector sec;
    rgbhsv_pkg::t_side   n_s1, r_s1;
    logic                r_s1_vld;
    logic [CW-1:0]       r_s1_abs;
    logic [CW-1:0]       n_s1_abs;

    always_comb begin
        r = i_pix.red_in;
        g = i_pix.green_in;
        b = i_pix.blue_in;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        if (r >= g && r >= b) begin
            sec  = rgbhsv_pkg::SEC_RED;
            diff = {1'b0, g} - {1'b0, b};
        end else if (g >= b) begin
            sec  = rgbhsv_pkg::SEC_GREEN;
            diff = {1'b0, b} - {1'b0, r};
        end else begin
            sec  = rgbhsv_pkg::SEC_BLUE;
            diff = {1'b0, r} - {1'b0, g};
        end
        n_s1.value  = mx;
        n_s1.delta  = mx - mn;
        n_s1.neg    = diff[CW];
        n_s1.sector = sec;
        n_s1.black  = (mx == '0);
        n_s1.grey   = (mx == mn);
        n_s1_abs    = diff[CW] ? CW'(-diff) : diff[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
        end
        if (en) begin
            r_s1     <= n_s1;
            r_s1_abs <= n_s1_abs;
        end
    end

    // ---- stage 2: dividends 255*delta and |diff|*3840
    rgbhsv_pkg::t_side r_s2;
    logic              r_s2_vld;
    logic [NW-1:0]     r_hue_num, r_sat_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
        if (en) begin
            r_s2      <= r_s1;
            r_hue_num <= {r_s1_abs, 12'd0} - {4'd0, r_s1_abs, 8'd0};
            r_sat_num <= {4'd0, r_s1.delta, 8'd0} - {12'd0, r_s1.delta};
        end
    end

    // ---- dividers, with sideband delayed alongside
    logic [QW-1:0] hue_q, sat_q;

    rgbhsv_divider u_hue_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_hue_num),
        .i_divisor  (r_s2.delta),
        .o_quotient (hue_q)
    );

    rgbhsv_divider u_sat_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_sat_num),
        .i_divisor  (r_s2.value),
        .o_quotient (sat_q)
    );

    rgbhsv_pkg::t_side r_side [QW];
    logic [QW-1:0]     r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[QW-2:0], r_s2_vld};
        end
        if (en) begin
            r_side[0] <= r_s2;
            for (int k = 1; k < QW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---- output stage: sector base, sign, special cases
    rgbhsv_pkg::t_side    sd;
    rgbhsv_pkg::t_hsv_out n_out;
    logic [HW-1:0]        base, q_ext;

    always_comb begin
        sd    = r_side[QW-1];
        q_ext = HW'(hue_q);
        case (sd.sector)
            rgbhsv_pkg::SEC_RED:   base = '0;
            rgbhsv_pkg::SEC_GREEN: base = HW'(2 * rgbhsv_pkg::HUE_SECTOR);
            rgbhsv_pkg::SEC_BLUE:  base = HW'(4 * rgbhsv_pkg::HUE_SECTOR);
            default:               base = '0;
        endcase
        n_out.value_out      = sd.value;
        n_out.saturation_out = sd.black ? '0 : sat_q[CW-1:0];
        if (sd.black || sd.grey) begin
            n_out.hue_out = '0;
        end else if (!sd.neg) begin
            n_out.hue_out = base + q_ext;
        end else if (base == '0 && q_ext != '0) begin
            // red sector, green below blue: wrap around the circle
            n_out.hue_out = rgbhsv_pkg::HUE_CIRCLE - q_ext;
        end else begin
            n_out.hue_out = base - q_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_vld[QW-1];
        end
        if (en) begin
            o_hsv <= n_out;
        end
    end

    // ---- checks
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hsv.hue_out < rgbhsv_pkg::HUE_CIRCLE)
        else $error("hue out of range");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hsv.value_out == '0) |->
            (o_hsv.saturation_out == '0 && o_hsv.hue_out == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hsv.saturation_out == '0) |-> o_hsv.hue_out == '0)
        else $error("zero saturation with nonzero hue");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_vld)
        else $error("accepted beat lost at pipeline entry");

endmodule

`default_nettype wire
